@@ design/afd_pkg.sv @@
// afd_pkg: shared constants, types and sizes for the anemometer frame deframer
// used by every design file of the deframer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int FRAME_BYTES = 18;
    localparam int STATUS_POS  = 16;
    localparam int CHECK_POS   = 17;
    localparam int DATA_BYTES  = 16;
    localparam int WORD_COUNT  = 8;

    localparam int PORT_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int POS_W     = 5;
    localparam int BIDX_W    = $clog2(DATA_BYTES);
    localparam int SEN_IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int ROW_W     = DATA_BYTES * BYTE_W;
    localparam int M_TDATA_W = WORD_COUNT * WORD_W;

    // one received byte in the working stage
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    // per-item decisions from the frame tracker
    typedef struct packed {
        logic              wr_en;
        logic [BIDX_W-1:0] wr_idx;
        logic              frame_ok;
    } t_track;

    // one decoded frame on its way to the output
    typedef struct packed {
        logic [PORT_W-1:0]    sensor;
        logic [M_TDATA_W-1:0] words;
    } t_result;

endpackage : afd_pkg

`default_nettype wire

@@ design/afd_frame_mem.sv @@
// afd_frame_mem: per-port row store for frame bytes 0 to 15
// byte writes at one row, registered row read; depends on afd_pkg
`timescale 1ns / 1ps
`default_nettype none

module afd_frame_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [afd_pkg::SEN_IDX_W-1:0] i_wr_sel,
    input  wire logic [afd_pkg::BIDX_W-1:0]    i_wr_idx,
    input  wire logic [afd_pkg::BYTE_W-1:0]    i_wr_byte,
    input  wire logic                          i_rd_en,
    input  wire logic [afd_pkg::SEN_IDX_W-1:0] i_rd_sel,
    output logic      [afd_pkg::ROW_W-1:0]     o_rd_row
);
    import afd_pkg::*;

    logic [ROW_W-1:0] r_mem [NUM_SENSORS];
    logic [ROW_W-1:0] r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_sel][i_wr_idx * BYTE_W +: BYTE_W] <= i_wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_sel];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule : afd_frame_mem

`default_nettype wire

@@ design/afd_frame_track.sv @@
// afd_frame_track: per-port byte position, running xor and status flag
// decides byte writes and frame acceptance; depends on afd_pkg
`timescale 1ns / 1ps
`default_nettype none

module afd_frame_track (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_fire,
    input  wire afd_pkg::t_item  i_item,
    output afd_pkg::t_track      o_track
);
    import afd_pkg::*;

    logic [POS_W-1:0]     r_pos     [NUM_SENSORS];
    logic [BYTE_W-1:0]    r_xor     [NUM_SENSORS];
    logic                 r_stat_ok [NUM_SENSORS];

    logic [SEN_IDX_W-1:0] sel;
    logic                 in_range;
    logic [POS_W-1:0]     pos_eff;
    logic                 is_last;

    assign sel      = SEN_IDX_W'(i_item.port);
    assign in_range = (5'(i_item.port) < 5'(NUM_SENSORS));

    always_comb begin
        pos_eff = r_pos[sel];
        if (pos_eff >= POS_W'(FRAME_BYTES)) begin
            pos_eff = '0;
        end
        is_last          = (pos_eff == POS_W'(CHECK_POS));
        o_track.wr_en    = i_valid && in_range && (pos_eff < POS_W'(DATA_BYTES));
        o_track.wr_idx   = pos_eff[BIDX_W-1:0];
        o_track.frame_ok = i_valid && in_range && is_last && r_stat_ok[sel]
                           && (i_item.data_byte == r_xor[sel]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_pos[k]     <= '0;
                r_xor[k]     <= '0;
                r_stat_ok[k] <= 1'b0;
            end
        end else if (i_fire && in_range) begin
            if (is_last) begin
                r_pos[sel] <= '0;
                r_xor[sel] <= '0;
            end else begin
                r_pos[sel] <= pos_eff + POS_W'(1);
                r_xor[sel] <= r_xor[sel] ^ i_item.data_byte;
                if (pos_eff == POS_W'(STATUS_POS)) begin
                    r_stat_ok[sel] <= (i_item.data_byte == '0);
                end
            end
        end
    end

endmodule : afd_frame_track

`default_nettype wire

@@ design/afd_out_skid.sv @@
// afd_out_skid: output register with one skid slot for decoded frames
// drives the master-side stream; depends on afd_pkg
`timescale 1ns / 1ps
`default_nettype none

module afd_out_skid (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire afd_pkg::t_result              i_result,
    output logic                               o_space,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [afd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic      [afd_pkg::PORT_W-1:0]    o_m_axis_tuser
);
    import afd_pkg::*;

    logic    r_out_valid;
    logic    r_sk_valid;
    t_result r_out;
    t_result r_sk;
    logic    out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out <= r_sk;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_sk <= i_result;
        end
    end

    assign o_space         = !r_sk_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.words;
    assign o_m_axis_tuser  = r_out.sensor;

endmodule : afd_out_skid

`default_nettype wire

@@ design/anemometer_frame_deframer_core.sv @@
// anemometer_frame_deframer_core: top level of the per-port 18-byte frame deframer
// built from afd_frame_mem, afd_frame_track and afd_out_skid; depends on afd_pkg
//
// usage
//   slave side: one received serial byte per word, tdata = data_byte, tuser = port
//   master side: one word per accepted frame, tuser = sensor and tdata holds the
//     eight 16-bit values wind_u, wind_v, wind_w, sonic_temp, analog_one to
//     analog_four from the lowest bit up
//   each port collects 18 bytes; the frame passes when status byte 16 is zero and
//   byte 17 equals the xor of bytes 0 to 16, otherwise it is dropped silently
//   either way the port restarts at byte 0; a port number out of range is ignored
// timing
//   one word accepted per cycle while no stall holds the input; the byte waits in the input
//   register, where the per-port position and xor are checked and updated
//   a frame result raises master tvalid after its last byte has gone through the
//   input register, then the output register; it may wait in the skid slot first
//   the frame row of that port is read from the row store as the byte is accepted
// reset
//   synchronous, active low: positions, xors and all valid flags clear; the row
//   store has no reset; a result uses a row only once all 16 data bytes are written
// stalls
//   an output register plus one skid slot; the input keeps flowing while a result
//   waits and only stops when both slots are full and another frame completes
`timescale 1ns / 1ps
`default_nettype none

module anemometer_frame_deframer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side: received bytes
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic [afd_pkg::PORT_W-1:0]    i_s_axis_tuser,  // [1:0] port
    // master side: decoded frames
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [15:0] wind_u, [31:16] wind_v, [47:32] wind_w, [63:48] sonic_temp,
    // [79:64] analog_one, [95:80] analog_two, [111:96] analog_three,
    // [127:112] analog_four
    output logic      [afd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic      [afd_pkg::PORT_W-1:0]    o_m_axis_tuser   // [1:0] sensor
);
    import afd_pkg::*;

    // input register
    logic             r_in_valid;
    t_item            r_in;

    logic             s_accept;
    logic             s1_fire;
    logic             out_space;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    t_track           track;
    t_result          result;

    // a byte can move on unless its frame completes while both output slots are full
    assign s1_fire         = r_in_valid && (!track.frame_ok || out_space);
    assign o_s_axis_tready = !r_in_valid || s1_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.port      <= i_s_axis_tuser;
            r_in.data_byte <= i_s_axis_tdata;
        end
    end

    // fetch the port's row alongside the byte; bytes 0 to 15 are already written
    // by the time byte 17 arrives
    assign rd_en = s_accept && (5'(i_s_axis_tuser) < 5'(NUM_SENSORS));

    afd_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (track.wr_en && s1_fire),
        .i_wr_sel  (SEN_IDX_W'(r_in.port)),
        .i_wr_idx  (track.wr_idx),
        .i_wr_byte (r_in.data_byte),
        .i_rd_en   (rd_en),
        .i_rd_sel  (SEN_IDX_W'(i_s_axis_tuser)),
        .o_rd_row  (rd_row)
    );

    afd_frame_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_fire  (s1_fire),
        .i_item  (r_in),
        .o_track (track)
    );

    // big-endian byte pairs into words, first word lowest
    always_comb begin
        result.sensor = r_in.port;
        for (int w = 0; w < WORD_COUNT; w++) begin
            result.words[w*WORD_W +: WORD_W] = {rd_row[(2*w)*BYTE_W +: BYTE_W],
                                                rd_row[(2*w+1)*BYTE_W +: BYTE_W]};
        end
    end

    afd_out_skid u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (s1_fire && track.frame_ok),
        .i_result        (result),
        .o_space         (out_space),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule : anemometer_frame_deframer_core

`default_nettype wire

@@ design/afd_checker.sv @@
// afd_checker: port-level checks for the deframer top level
// bound to anemometer_frame_deframer_core; depends on afd_pkg
`timescale 1ns / 1ps
`default_nettype none

module afd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_axis_tvalid,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [afd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [afd_pkg::PORT_W-1:0]    o_m_axis_tuser
);
    import afd_pkg::*;

    // a held result word stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // and does not change meanwhile
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // reset empties the output slots
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a fresh result has a byte taken into the input register behind it
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result appeared with no byte behind it");

endmodule : afd_checker

bind anemometer_frame_deframer_core afd_checker u_afd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
